@@ rtl/core/nhsv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register indexes for the normalized HSV to RGB core.
// No dependencies.
package nhsv_pkg;

   localparam int SAMPLE_BITS       = 16;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int IO_BITS           = 16;
   localparam int MODE_BITS         = 6;
   localparam int CONST_BITS        = 48;
   localparam int CSR_INDEX_BITS    = 4;
   localparam int CSR_DATA_BITS     = 48;
   localparam int NUM_LANES         = 3;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODES    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_LOW  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HUE_HIGH = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAT_LOW  = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAT_HIGH = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VAL_LOW  = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VAL_HIGH = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONSTS   = 4'd7;

   // how a lane's fraction is formed once the item reaches the back end
   typedef enum logic [2:0] {
      KIND_DIV   = 3'd0,
      KIND_LOW   = 3'd1,
      KIND_HIGH  = 3'd2,
      KIND_EMPTY = 3'd3,
      KIND_CONST = 3'd4
   } kind_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] hue_sample;
      logic signed [SAMPLE_BITS-1:0] sat_sample;
      logic signed [SAMPLE_BITS-1:0] val_sample;
      logic                          last_in;
   } req_type;

   typedef struct packed {
      logic [IO_BITS-1:0] red;
      logic [IO_BITS-1:0] green;
      logic [IO_BITS-1:0] blue;
      logic               last_out;
   } rsp_type;

   typedef struct packed {
      kind_type               kind;
      logic                   invert;
      logic [IO_BITS-1:0]     cval;
      logic [SAMPLE_BITS-1:0] num;   // x - low, becomes the remainder in the divider
      logic [SAMPLE_BITS-1:0] den;   // high - low
   } lane_type;

   typedef struct packed {
      lane_type [NUM_LANES-1:0] lane;
      logic                     last;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/core/normalized_hsv_to_rgb_core.sv @@
`timescale 1ns / 1ps
// Top level of the normalized HSV to RGB core: front end, item queue, back end.
// Depends on nhsv_pkg, nhsv_front, nhsv_queue, nhsv_back.
//
//   channel   ports                                   handshake
//   request   start, busy, req_data                   taken when start && !busy
//   response  rsp_valid, rsp_data                     one-cycle strobe, no back-pressure
//   config    csr_valid, csr_ready, csr_index/data    written when valid && ready
//
// One item per cycle sustained. Each item passes the front register, the item queue,
// the one-bit-per-stage divider pipeline and the back-end math stages in turn.
// Reset is synchronous; it clears the pipeline and loads the register defaults.
// The back end never stalls, so busy only rises if the queue were full.
module normalized_hsv_to_rgb_core #(
   parameter int FRACTION_BITS = nhsv_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  nhsv_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output nhsv_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nhsv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nhsv_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   nhsv_pkg::work_type         front_work, queue_work;
   nhsv_pkg::queue_status_type qstat;
   logic                       push, pop;

   assign csr_ready = 1'b1;
   assign pop       = ~qstat.empty;

   nhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .qstat     (qstat),
      .push      (push),
      .work      (front_work)
   );

   nhsv_queue #(
      .DEPTH (nhsv_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_work),
      .pop       (pop),
      .pop_data  (queue_work),
      .status    (qstat)
   );

   nhsv_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop),
      .in_work   (queue_work),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/nhsv_front.sv @@
`timescale 1ns / 1ps
// Front end: configuration registers, item accept and per-channel classification.
// Depends on nhsv_pkg.
module nhsv_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  nhsv_pkg::req_type                      req_data,
   input  logic                                   csr_valid,
   input  logic [nhsv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [nhsv_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  nhsv_pkg::queue_status_type             qstat,
   output logic                                   push,
   output nhsv_pkg::work_type                     work
);

   localparam int SB = nhsv_pkg::SAMPLE_BITS;
   localparam int NL = nhsv_pkg::NUM_LANES;

   logic [nhsv_pkg::MODE_BITS-1:0]  modes_ff;
   logic [nhsv_pkg::CONST_BITS-1:0] consts_ff;
   logic signed [SB-1:0]            low_ff  [NL];
   logic signed [SB-1:0]            high_ff [NL];

   logic               valid_ff, valid_in;
   nhsv_pkg::work_type work_ff, work_in;
   logic               accept;

   logic signed [SB-1:0] samp [NL];
   logic signed [SB:0]   dx   [NL];
   logic signed [SB:0]   dr   [NL];

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff  <= '0;
         consts_ff <= '0;
         for (int i = 0; i < NL; i++) begin
            low_ff[i]  <= {1'b1, {(SB-1){1'b0}}};
            high_ff[i] <= {1'b0, {(SB-1){1'b1}}};
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            nhsv_pkg::CSR_MODES:    modes_ff   <= csr_data[nhsv_pkg::MODE_BITS-1:0];
            nhsv_pkg::CSR_HUE_LOW:  low_ff[0]  <= csr_data[SB-1:0];
            nhsv_pkg::CSR_HUE_HIGH: high_ff[0] <= csr_data[SB-1:0];
            nhsv_pkg::CSR_SAT_LOW:  low_ff[1]  <= csr_data[SB-1:0];
            nhsv_pkg::CSR_SAT_HIGH: high_ff[1] <= csr_data[SB-1:0];
            nhsv_pkg::CSR_VAL_LOW:  low_ff[2]  <= csr_data[SB-1:0];
            nhsv_pkg::CSR_VAL_HIGH: high_ff[2] <= csr_data[SB-1:0];
            nhsv_pkg::CSR_CONSTS:   consts_ff  <= csr_data[nhsv_pkg::CONST_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign samp[0] = req_data.hue_sample;
   assign samp[1] = req_data.sat_sample;
   assign samp[2] = req_data.val_sample;

   always_comb begin
      work_in      = work_ff;
      work_in.last = req_data.last_in;
      for (int i = 0; i < NL; i++) begin
         dx[i] = {samp[i][SB-1], samp[i]} - {low_ff[i][SB-1], low_ff[i]};
         dr[i] = {high_ff[i][SB-1], high_ff[i]} - {low_ff[i][SB-1], low_ff[i]};
         // both differences are below 2^SB whenever the lane divides
         work_in.lane[i].num    = dx[i][SB-1:0];
         work_in.lane[i].den    = dr[i][SB-1:0];
         work_in.lane[i].cval   = consts_ff[nhsv_pkg::IO_BITS*i +: nhsv_pkg::IO_BITS];
         work_in.lane[i].invert = modes_ff[2*i];
         if (modes_ff[2*i+1])
            work_in.lane[i].kind = nhsv_pkg::KIND_CONST;
         else if (high_ff[i] <= low_ff[i])
            work_in.lane[i].kind = nhsv_pkg::KIND_EMPTY;
         else if (samp[i] <= low_ff[i])
            work_in.lane[i].kind = nhsv_pkg::KIND_LOW;
         else if (samp[i] >= high_ff[i])
            work_in.lane[i].kind = nhsv_pkg::KIND_HIGH;
         else
            work_in.lane[i].kind = nhsv_pkg::KIND_DIV;
      end
   end

   assign busy     = valid_ff & qstat.full;
   assign accept   = start & ~busy;
   assign push     = valid_ff & ~qstat.full;
   assign valid_in = accept | (valid_ff & ~push);
   assign work     = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

@@ rtl/core/nhsv_queue.sv @@
`timescale 1ns / 1ps
// Short item queue between the front and back ends.
// Depends on nhsv_pkg.
module nhsv_queue #(
   parameter int DEPTH = nhsv_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nhsv_pkg::work_type         push_data,
   input  logic                       pop,
   output nhsv_pkg::work_type         pop_data,
   output nhsv_pkg::queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   nhsv_pkg::work_type slot_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(DEPTH - 1))
         r = '0;
      else
         r = p + 1'b1;
      return r;
   endfunction

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full && !pop)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty)) else $error("queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/nhsv_back.sv @@
`timescale 1ns / 1ps
// Back end: pipelined restoring dividers for the three channels, then the
// six-sector HSV to RGB math and the output register. Depends on nhsv_pkg.
module nhsv_back #(
   parameter int FRACTION_BITS = nhsv_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  nhsv_pkg::work_type in_work,
   output logic               rsp_valid,
   output nhsv_pkg::rsp_type  rsp_data
);

   localparam int FB = FRACTION_BITS;
   localparam int SB = nhsv_pkg::SAMPLE_BITS;
   localparam int NL = nhsv_pkg::NUM_LANES;
   localparam int OB = nhsv_pkg::IO_BITS;
   localparam logic [FB:0] FRAC_ONE = {1'b1, {FB{1'b0}}};

   localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;

   // divider pipeline: stage k holds k quotient bits per lane
   nhsv_pkg::work_type st_work_ff  [FB+1];
   logic [FB-1:0]      st_quo_ff   [FB+1][NL];
   logic               st_valid_ff [FB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else begin
         st_valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      st_work_ff[0] <= in_work;
      for (int i = 0; i < NL; i++) begin
         st_quo_ff[0][i] <= '0;
      end
   end

   for (genvar k = 0; k < FB; k++) begin : g_div
      nhsv_pkg::work_type work_in;
      logic [FB-1:0]      quo_in [NL];

      always_comb begin
         logic [SB:0] r2;
         logic [SB:0] dd;
         work_in = st_work_ff[k];
         for (int i = 0; i < NL; i++) begin
            r2 = {st_work_ff[k].lane[i].num, 1'b0};
            dd = {1'b0, st_work_ff[k].lane[i].den};
            if (r2 >= dd) begin
               work_in.lane[i].num = SB'(r2 - dd);
               quo_in[i] = {st_quo_ff[k][i][FB-2:0], 1'b1};
            end else begin
               work_in.lane[i].num = r2[SB-1:0];
               quo_in[i] = {st_quo_ff[k][i][FB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k+1] <= 1'b0;
         end else begin
            st_valid_ff[k+1] <= st_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         st_work_ff[k+1] <= work_in;
         for (int i = 0; i < NL; i++) begin
            st_quo_ff[k+1][i] <= quo_in[i];
         end
      end
   end

   function automatic logic [FB-1:0] lane_frac(nhsv_pkg::lane_type ln, logic [FB-1:0] q);
      logic [FB+15:0] wide;
      logic [FB-1:0]  r;
      wide = {ln.cval, {FB{1'b0}}};
      unique case (ln.kind)
         nhsv_pkg::KIND_CONST: r = wide[FB+15:16];
         nhsv_pkg::KIND_LOW:   r = ln.invert ? '1 : '0;
         nhsv_pkg::KIND_HIGH:  r = ln.invert ? '0 : '1;
         nhsv_pkg::KIND_DIV: begin
            // inverted: ONE - q, saturating when q is zero
            if (!ln.invert)
               r = q;
            else if (q == '0)
               r = '1;
            else
               r = (~q) + {{(FB-1){1'b0}}, 1'b1};
         end
         default:              r = '0;
      endcase
      return r;
   endfunction

   // stage A: channel fractions
   logic          valid_a_ff, last_a_ff;
   logic [FB-1:0] h_a_ff, s_a_ff, v_a_ff;

   // stage B: sector and f
   logic          valid_b_ff, last_b_ff;
   logic [2:0]    sector_b_ff;
   logic [FB-1:0] f_b_ff, s_b_ff, v_b_ff;
   logic [FB+2:0] h6_in;

   // stage C: multipliers of p, q, t
   logic          valid_c_ff, last_c_ff;
   logic [2:0]    sector_c_ff;
   logic [FB-1:0] v_c_ff;
   logic [FB:0]   a1_c_ff, a2_c_ff, a3_c_ff;
   logic [2*FB-1:0] sf_in;
   logic [FB:0]     omf_in;
   logic [2*FB:0]   sfi_in;

   // stage D: p, q, t
   logic          valid_d_ff, last_d_ff;
   logic [2:0]    sector_d_ff;
   logic [FB-1:0] v_d_ff, p_d_ff, q_d_ff, t_d_ff;
   logic [2*FB:0] pv_in, qv_in, tv_in;

   // stage E: output register
   logic              rsp_valid_ff;
   nhsv_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [FB-1:0]     r_sel, g_sel, b_sel;

   assign h6_in  = {3'b000, h_a_ff} * (FB+3)'(6);
   assign sf_in  = s_b_ff * f_b_ff;
   assign omf_in = FRAC_ONE - {1'b0, f_b_ff};
   assign sfi_in = s_b_ff * omf_in;
   assign pv_in  = v_c_ff * a1_c_ff;
   assign qv_in  = v_c_ff * a2_c_ff;
   assign tv_in  = v_c_ff * a3_c_ff;

   function automatic logic [OB-1:0] to_out(logic [FB-1:0] c);
      logic [FB+OB-1:0] wide;
      wide = {c, {OB{1'b0}}};
      return wide[FB+OB-1:FB];
   endfunction

   always_comb begin
      case (sector_d_ff)
         SECTOR_RED_YELLOW:   begin r_sel = v_d_ff; g_sel = t_d_ff; b_sel = p_d_ff; end
         SECTOR_YELLOW_GREEN: begin r_sel = q_d_ff; g_sel = v_d_ff; b_sel = p_d_ff; end
         SECTOR_GREEN_CYAN:   begin r_sel = p_d_ff; g_sel = v_d_ff; b_sel = t_d_ff; end
         SECTOR_CYAN_BLUE:    begin r_sel = p_d_ff; g_sel = q_d_ff; b_sel = v_d_ff; end
         SECTOR_BLUE_MAGENTA: begin r_sel = t_d_ff; g_sel = p_d_ff; b_sel = v_d_ff; end
         default:             begin r_sel = v_d_ff; g_sel = p_d_ff; b_sel = q_d_ff; end
      endcase
      if (v_d_ff == '0) begin
         r_sel = '0;
         g_sel = '0;
         b_sel = '0;
      end
      rsp_data_in.red      = to_out(r_sel);
      rsp_data_in.green    = to_out(g_sel);
      rsp_data_in.blue     = to_out(b_sel);
      rsp_data_in.last_out = last_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         valid_d_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= st_valid_ff[FB];
         valid_b_ff   <= valid_a_ff;
         valid_c_ff   <= valid_b_ff;
         valid_d_ff   <= valid_c_ff;
         rsp_valid_ff <= valid_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      h_a_ff    <= lane_frac(st_work_ff[FB].lane[0], st_quo_ff[FB][0]);
      s_a_ff    <= lane_frac(st_work_ff[FB].lane[1], st_quo_ff[FB][1]);
      v_a_ff    <= lane_frac(st_work_ff[FB].lane[2], st_quo_ff[FB][2]);
      last_a_ff <= st_work_ff[FB].last;

      sector_b_ff <= h6_in[FB+2:FB];
      f_b_ff      <= h6_in[FB-1:0];
      s_b_ff      <= s_a_ff;
      v_b_ff      <= v_a_ff;
      last_b_ff   <= last_a_ff;

      a1_c_ff     <= FRAC_ONE - {1'b0, s_b_ff};
      a2_c_ff     <= FRAC_ONE - {1'b0, sf_in[2*FB-1:FB]};
      a3_c_ff     <= FRAC_ONE - {1'b0, sfi_in[2*FB-1:FB]};
      v_c_ff      <= v_b_ff;
      sector_c_ff <= sector_b_ff;
      last_c_ff   <= last_b_ff;

      p_d_ff      <= pv_in[2*FB-1:FB];
      q_d_ff      <= qv_in[2*FB-1:FB];
      t_d_ff      <= tv_in[2*FB-1:FB];
      v_d_ff      <= v_c_ff;
      sector_d_ff <= sector_c_ff;
      last_d_ff   <= last_c_ff;

      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_black_on_zero_value: assert property (@(posedge clock) disable iff (reset)
      (valid_d_ff && v_d_ff == '0) |=>
         (rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0))
      else $error("zero brightness did not give black");
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff |-> (sector_b_ff <= 3'd5)) else $error("hue sector out of range");
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid, FB + 6)) else $error("result without matching item");
`endif

endmodule

@@ tb/sv/normalized_hsv_to_rgb_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for normalized_hsv_to_rgb_core: directed and random pixels checked
// against an in-bench HSV to RGB predictor. Depends on nhsv_pkg and the core.
module normalized_hsv_to_rgb_core_tb;

   localparam int FB = nhsv_pkg::FRACTION_BITS_DEF;
   localparam longint ONE_F = 64'd1 << FB;
   localparam longint MAX_F = ONE_F - 1;
   localparam int LATENCY = FB + 8;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   nhsv_pkg::req_type req_data = '0;
   logic rsp_valid;
   nhsv_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [nhsv_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [nhsv_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   normalized_hsv_to_rgb_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // shadow copy of the color registers
   logic [5:0] mode_shadow;
   logic signed [15:0] low_shadow [3];
   logic signed [15:0] high_shadow [3];
   logic [47:0] const_shadow;

   nhsv_pkg::rsp_type pixel_queue [$];
   int errors = 0;
   longint cycles = 0;
   bit idle_off = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic longint lane_fraction(int ch, logic signed [15:0] x);
      logic [1:0] m;
      longint lo, hi, n;
      m = mode_shadow[2*ch +: 2];
      if (m >= 2) begin
         n = const_shadow[16*ch +: 16];
         return n > MAX_F ? MAX_F : n;
      end
      lo = low_shadow[ch];
      hi = high_shadow[ch];
      if (hi <= lo) return 0;
      if (x <= lo) n = 0;
      else if (x >= hi) n = ONE_F;
      else n = ((longint'(x) - lo) << FB) / (hi - lo);
      if (m == 1) n = ONE_F - n;
      return n > MAX_F ? MAX_F : n;
   endfunction

   function automatic nhsv_pkg::rsp_type hsv_pixel(nhsv_pkg::req_type r);
      longint h, s, v, h6, sec, f, p, q, t, rr, gg, bb;
      nhsv_pkg::rsp_type o;
      h = lane_fraction(0, r.hue_sample);
      s = lane_fraction(1, r.sat_sample);
      v = lane_fraction(2, r.val_sample);
      rr = 0; gg = 0; bb = 0;
      if (v != 0) begin
         h6 = h * 6;
         sec = h6 >> FB;
         f = h6 & MAX_F;
         p = (v * (ONE_F - s)) >> FB;
         q = (v * (ONE_F - ((s * f) >> FB))) >> FB;
         t = (v * (ONE_F - ((s * (ONE_F - f)) >> FB))) >> FB;
         case (sec)
            0: begin rr = v; gg = t; bb = p; end
            1: begin rr = q; gg = v; bb = p; end
            2: begin rr = p; gg = v; bb = t; end
            3: begin rr = p; gg = q; bb = v; end
            4: begin rr = t; gg = p; bb = v; end
            default: begin rr = v; gg = p; bb = q; end
         endcase
      end
      o.red = 16'(rr > MAX_F ? MAX_F : rr);
      o.green = 16'(gg > MAX_F ? MAX_F : gg);
      o.blue = 16'(bb > MAX_F ? MAX_F : bb);
      o.last_out = r.last_in;
      return o;
   endfunction

   always @(posedge clock) begin
      nhsv_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pixel_queue.size() == 0) begin
            $display("%0t unexpected pixel, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                rsp_data.blue !== want.blue || rsp_data.last_out !== want.last_out) begin
               $display("%0t mismatch: expected r%h g%h b%h l%b, actual r%h g%h b%h l%b",
                        $time, want.red, want.green, want.blue, want.last_out,
                        rsp_data.red, rsp_data.green, rsp_data.blue, rsp_data.last_out);
               errors++;
            end
         end
      end
   end

   task automatic send_pixel(logic [15:0] hs, logic [15:0] ss, logic [15:0] vs, bit last);
      nhsv_pkg::req_type r;
      while (!idle_off && $urandom_range(99) < 16) begin
         start <= 1'b0;
         @(posedge clock);
      end
      r.hue_sample = hs;
      r.sat_sample = ss;
      r.val_sample = vs;
      r.last_in = last;
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pixel_queue.push_back(hsv_pixel(r));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [nhsv_pkg::CSR_INDEX_BITS-1:0] idx, logic [47:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         nhsv_pkg::CSR_MODES: mode_shadow = val[5:0];
         nhsv_pkg::CSR_HUE_LOW: low_shadow[0] = val[15:0];
         nhsv_pkg::CSR_HUE_HIGH: high_shadow[0] = val[15:0];
         nhsv_pkg::CSR_SAT_LOW: low_shadow[1] = val[15:0];
         nhsv_pkg::CSR_SAT_HIGH: high_shadow[1] = val[15:0];
         nhsv_pkg::CSR_VAL_LOW: low_shadow[2] = val[15:0];
         nhsv_pkg::CSR_VAL_HIGH: high_shadow[2] = val[15:0];
         nhsv_pkg::CSR_CONSTS: const_shadow = val;
         default: ;
      endcase
   endtask

   task automatic set_bounds(int ch, logic [15:0] lo, logic [15:0] hi);
      write_reg(nhsv_pkg::CSR_INDEX_BITS'(nhsv_pkg::CSR_HUE_LOW + 2*ch), {32'd0, lo});
      write_reg(nhsv_pkg::CSR_INDEX_BITS'(nhsv_pkg::CSR_HUE_HIGH + 2*ch), {32'd0, hi});
   endtask

   task automatic send_random(int n);
      for (int i = 0; i < n; i++)
         send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
   endtask

   // default full range: field extremes, every hue sector, grays and black
   task automatic test_extremes;
      send_pixel(16'h8000, 16'h8000, 16'h8000, 0);
      send_pixel(16'h7fff, 16'h7fff, 16'h7fff, 1);
      send_pixel(16'h0000, 16'h7fff, 16'h7fff, 0);
      send_pixel(16'hffff, 16'h8000, 16'h4000, 1);
      for (int k = 0; k < 6; k++)
         send_pixel(16'(16'h8000 + k * 16'h2aab + 16'h1000), 16'h7000, 16'h6000, k[0]);
      send_pixel(16'h5555, 16'h7fff, 16'h8000, 0);
      drain();
   endtask

   // inverted lanes, empty and reversed ranges, narrow ranges that saturate
   task automatic test_modes;
      write_reg(nhsv_pkg::CSR_MODES, 48'(6'b01_01_01));
      set_bounds(0, 16'hfc00, 16'h0400);
      set_bounds(1, 16'h0010, 16'h0010);
      set_bounds(2, 16'h0100, 16'h00ff);
      send_pixel(16'h0000, 16'h0010, 16'h0100, 1);
      send_pixel(16'hfc00, 16'h7fff, 16'h8000, 0);
      drain();
      write_reg(nhsv_pkg::CSR_MODES, 48'(6'b00_01_00));
      set_bounds(1, 16'hffff, 16'h0001);
      set_bounds(2, 16'h0000, 16'h0001);
      send_pixel(16'h0400, 16'h0000, 16'h0001, 1);
      send_pixel(16'h0123, 16'hffff, 16'h0000, 0);
      send_pixel(16'hfd00, 16'h0001, 16'h7fff, 1);
      drain();
   endtask

   // constant lanes, including all-ones and zero constants
   task automatic test_constants;
      write_reg(nhsv_pkg::CSR_MODES, 48'(6'b11_10_11));
      write_reg(nhsv_pkg::CSR_CONSTS, 48'hffff_ffff_ffff);
      send_pixel(16'h1234, 16'h5678, 16'h9abc, 1);
      drain();
      write_reg(nhsv_pkg::CSR_CONSTS, 48'h8000_0000_aaaa);
      send_pixel(16'h0000, 16'h0000, 16'h0000, 0);
      drain();
      write_reg(nhsv_pkg::CSR_MODES, 48'(6'b10_00_00));
      send_pixel(16'h7fff, 16'h8000, 16'h0000, 1);
      drain();
   endtask

   // random pixels under random settings; one phase without random gaps between pixels
   task automatic test_random;
      for (int phase = 0; phase < 10; phase++) begin
         write_reg(nhsv_pkg::CSR_MODES, 48'($urandom_range(63)));
         for (int ch = 0; ch < 3; ch++)
            if ($urandom_range(3) == 0) set_bounds(ch, 16'($urandom), 16'($urandom));
            else set_bounds(ch, 16'(16'h8000 + $urandom_range(16'h7fff)),
                            16'(16'h7fff - $urandom_range(16'h7fff)));
         write_reg(nhsv_pkg::CSR_CONSTS, 48'({$urandom, $urandom}));
         idle_off = (phase == 4);
         send_random(70);
         // hold off until the pipeline is empty, then resume
         start <= 1'b0;
         while (pixel_queue.size() != 0) @(posedge clock);
         send_random(70);
         drain();
      end
      idle_off = 0;
   endtask

   initial begin
      mode_shadow = 0;
      for (int ch = 0; ch < 3; ch++) begin
         low_shadow[ch] = 16'sh8000;
         high_shadow[ch] = 16'sh7fff;
      end
      const_shadow = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (LATENCY + 4) @(posedge clock);
      test_extremes();
      test_modes();
      test_constants();
      test_random();
      drain();
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

@@ files.f @@
rtl/core/nhsv_pkg.sv
rtl/core/nhsv_front.sv
rtl/core/nhsv_queue.sv
rtl/core/nhsv_back.sv
rtl/core/normalized_hsv_to_rgb_core.sv
tb/sv/normalized_hsv_to_rgb_core_tb.sv
